>>> sv/lcs_length_three_strings_assert.svh
// assertion macros used by the lcs3 top level
`ifndef LCS_LENGTH_THREE_STRINGS_ASSERT_SVH
`define LCS_LENGTH_THREE_STRINGS_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LCS3_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define LCS3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/lcs3_pkg.sv
// shared constants, codes and types of the three-string lcs engine
package lcs3_pkg;

  localparam int MAX_LEN     = 64;
  localparam int LEN_W       = $clog2(MAX_LEN + 1);
  localparam int IDX_W       = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int PLANE_DEPTH = MAX_LEN * MAX_LEN;
  localparam int PADDR_W     = (PLANE_DEPTH > 1) ? $clog2(PLANE_DEPTH) : 1;
  localparam int CMD_W       = 2;
  localparam int CH_W        = 8;
  localparam int LCS_W       = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND_A = 2'd0,
    CMD_APPEND_B = 2'd1,
    CMD_APPEND_C = 2'd2,
    CMD_COMPUTE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // one table cell handed from the sequencer to the cell datapath
  typedef struct packed {
    logic               valid;
    logic               first_plane;
    logic               first_row;
    logic               first_col;
    logic               last;
    logic [PADDR_W-1:0] paddr;
    logic [IDX_W-1:0]   kaddr;
  } cell_issue_t;

  typedef struct packed {
    logic             valid;
    logic [LEN_W-1:0] score;
  } cell_rsp_t;

endpackage

>>> sv/lcs_length_three_strings.sv
// Longest common subsequence length of three byte strings.
// Input channel (in_valid/in_ready, in_cmd, in_ch): commands 0..2 append
// in_ch to string A, B or C; command 3 computes. Appends give no result;
// a character beyond 64 in a string is dropped and sets the overflow flag.
// Result channel (out_valid/out_ready, out_lcs_len, out_overflow): one
// transaction per compute. The walk evaluates one table cell per cycle
// through the score plane memory (read, compute, write back), so the three
// lengths set the time of a compute. If any string is empty the walk is
// skipped and a result of zero is given from the done state.
// After each result the lengths and the overflow flag return to zero.
// Reset (rst_n low, synchronous) empties the strings and drops any
// pending result; no memory clearing pass is needed.
// A stalled receiver holds the result in the output register; appends are
// still taken meanwhile, and the next compute runs its walk, then waits for the slot.
module lcs_length_three_strings (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lcs3_pkg::CMD_W-1:0]  in_cmd,
  input  logic [lcs3_pkg::CH_W-1:0]   in_ch,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lcs3_pkg::LCS_W-1:0]  out_lcs_len,
  output logic                        out_overflow
);
  import lcs3_pkg::*;

  `include "lcs_length_three_strings_assert.svh"

  logic [2:0]       str_we;
  logic [IDX_W-1:0] str_waddr;
  logic [CH_W-1:0]  str_wdata;
  logic [IDX_W-1:0] rd_a, rd_b, rd_c;
  logic [CH_W-1:0]  ch_a, ch_b, ch_c;
  cell_issue_t      issue_s;
  cell_rsp_t        rsp_s;

  lcs3_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_ch        (in_ch),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_lcs_len  (out_lcs_len),
    .out_overflow (out_overflow),
    .str_we       (str_we),
    .str_waddr    (str_waddr),
    .str_wdata    (str_wdata),
    .rd_a         (rd_a),
    .rd_b         (rd_b),
    .rd_c         (rd_c),
    .issue        (issue_s),
    .rsp          (rsp_s)
  );

  lcs3_ram #(.WIDTH(CH_W), .DEPTH(MAX_LEN)) u_str_a (
    .clk   (clk),
    .we    (str_we[0]),
    .waddr (str_waddr),
    .wdata (str_wdata),
    .raddr (rd_a),
    .rdata (ch_a)
  );

  lcs3_ram #(.WIDTH(CH_W), .DEPTH(MAX_LEN)) u_str_b (
    .clk   (clk),
    .we    (str_we[1]),
    .waddr (str_waddr),
    .wdata (str_wdata),
    .raddr (rd_b),
    .rdata (ch_b)
  );

  lcs3_ram #(.WIDTH(CH_W), .DEPTH(MAX_LEN)) u_str_c (
    .clk   (clk),
    .we    (str_we[2]),
    .waddr (str_waddr),
    .wdata (str_wdata),
    .raddr (rd_c),
    .rdata (ch_c)
  );

  lcs3_cell u_cell (
    .clk   (clk),
    .rst_n (rst_n),
    .issue (issue_s),
    .ch_a  (ch_a),
    .ch_b  (ch_b),
    .ch_c  (ch_c),
    .rsp   (rsp_s)
  );

  `LCS3_ASSERT_NEXT(a_last_cell_rsp, issue_s.valid && issue_s.last, rsp_s.valid, "no last result")
  `LCS3_ASSERT_NOW(a_no_accept_busy, in_ready, !issue_s.valid && !rsp_s.valid, "ready in walk")
  `LCS3_ASSERT_NOW(a_one_str_write, in_valid && in_ready, $onehot0(str_we), "several string writes")

endmodule

>>> sv/lcs3_ram.sv
// generic single-write, single-read synchronous ram with registered read
module lcs3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/lcs3_ctrl.sv
// sequencer: string loading, lengths, cell walk and result register
module lcs3_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lcs3_pkg::CMD_W-1:0]    in_cmd,
  input  logic [lcs3_pkg::CH_W-1:0]     in_ch,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lcs3_pkg::LCS_W-1:0]    out_lcs_len,
  output logic                          out_overflow,
  output logic [2:0]                    str_we,
  output logic [lcs3_pkg::IDX_W-1:0]    str_waddr,
  output logic [lcs3_pkg::CH_W-1:0]     str_wdata,
  output logic [lcs3_pkg::IDX_W-1:0]    rd_a,
  output logic [lcs3_pkg::IDX_W-1:0]    rd_b,
  output logic [lcs3_pkg::IDX_W-1:0]    rd_c,
  output lcs3_pkg::cell_issue_t         issue,
  input  lcs3_pkg::cell_rsp_t           rsp
);
  import lcs3_pkg::*;

  localparam logic [LEN_W-1:0] FULL = LEN_W'(MAX_LEN);
  localparam logic [LEN_W-1:0] ONE  = LEN_W'(1);

  state_t             state_r, state_nxt;
  logic [LEN_W-1:0]   len_a_r, len_a_nxt;
  logic [LEN_W-1:0]   len_b_r, len_b_nxt;
  logic [LEN_W-1:0]   len_c_r, len_c_nxt;
  logic               ovf_r, ovf_nxt;
  logic [IDX_W-1:0]   i_r, i_nxt;
  logic [IDX_W-1:0]   j_r, j_nxt;
  logic [IDX_W-1:0]   k_r, k_nxt;
  logic [PADDR_W-1:0] paddr_r, paddr_nxt;
  logic [LEN_W-1:0]   res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [LCS_W-1:0]   out_len_r, out_len_nxt;
  logic               out_ovf_r, out_ovf_nxt;
  logic               i_end, j_end, k_end;
  cmd_t               cmd;

  assign cmd   = cmd_t'(in_cmd);
  assign i_end = (LEN_W'(i_r) + ONE) == len_a_r;
  assign j_end = (LEN_W'(j_r) + ONE) == len_b_r;
  assign k_end = (LEN_W'(k_r) + ONE) == len_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_a_r     <= '0;
      len_b_r     <= '0;
      len_c_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_a_r     <= len_a_nxt;
      len_b_r     <= len_b_nxt;
      len_c_r     <= len_c_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    k_r       <= k_nxt;
    paddr_r   <= paddr_nxt;
    res_r     <= res_nxt;
    out_len_r <= out_len_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    len_a_nxt     = len_a_r;
    len_b_nxt     = len_b_r;
    len_c_nxt     = len_c_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    paddr_nxt     = paddr_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_len_nxt   = out_len_r;
    out_ovf_nxt   = out_ovf_r;
    str_we        = 3'b000;
    issue         = '0;
    in_ready      = (state_r == ST_IDLE);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (cmd)
            CMD_APPEND_A: begin
              if (len_a_r == FULL) begin
                ovf_nxt = 1'b1;
              end else begin
                str_we[0] = 1'b1;
                len_a_nxt = len_a_r + ONE;
              end
            end
            CMD_APPEND_B: begin
              if (len_b_r == FULL) begin
                ovf_nxt = 1'b1;
              end else begin
                str_we[1] = 1'b1;
                len_b_nxt = len_b_r + ONE;
              end
            end
            CMD_APPEND_C: begin
              if (len_c_r == FULL) begin
                ovf_nxt = 1'b1;
              end else begin
                str_we[2] = 1'b1;
                len_c_nxt = len_c_r + ONE;
              end
            end
            CMD_COMPUTE: begin
              i_nxt     = '0;
              j_nxt     = '0;
              k_nxt     = '0;
              paddr_nxt = '0;
              // an empty string leaves nothing to walk
              if (len_a_r == '0 || len_b_r == '0 || len_c_r == '0) begin
                res_nxt   = '0;
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_RUN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        issue.valid       = 1'b1;
        issue.first_plane = (i_r == '0);
        issue.first_row   = (j_r == '0);
        issue.first_col   = (k_r == '0);
        issue.last        = i_end && j_end && k_end;
        issue.paddr       = paddr_r;
        issue.kaddr       = k_r;
        if (k_end) begin
          k_nxt = '0;
          if (j_end) begin
            j_nxt     = '0;
            paddr_nxt = '0;
            if (i_end) begin
              state_nxt = ST_DRAIN;
            end else begin
              i_nxt = i_r + IDX_W'(1);
            end
          end else begin
            j_nxt     = j_r + IDX_W'(1);
            paddr_nxt = paddr_r + PADDR_W'(1);
          end
        end else begin
          k_nxt     = k_r + IDX_W'(1);
          paddr_nxt = paddr_r + PADDR_W'(1);
        end
      end
      ST_DRAIN: begin
        if (rsp.valid) begin
          res_nxt   = rsp.score;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_len_nxt   = LCS_W'(res_r);
          out_ovf_nxt   = ovf_r;
          len_a_nxt     = '0;
          len_b_nxt     = '0;
          len_c_nxt     = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    case (cmd)
      CMD_APPEND_A: str_waddr = len_a_r[IDX_W-1:0];
      CMD_APPEND_B: str_waddr = len_b_r[IDX_W-1:0];
      default:      str_waddr = len_c_r[IDX_W-1:0];
    endcase
  end

  assign str_wdata    = in_ch;
  assign rd_a         = i_r;
  assign rd_b         = j_r;
  assign rd_c         = k_r;
  assign out_valid    = out_valid_r;
  assign out_lcs_len  = out_len_r;
  assign out_overflow = out_ovf_r;

endmodule

>>> sv/lcs3_cell.sv
// cell datapath: score plane and row memories, recurrence and forwarding
module lcs3_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lcs3_pkg::cell_issue_t      issue,
  input  logic [lcs3_pkg::CH_W-1:0]  ch_a,
  input  logic [lcs3_pkg::CH_W-1:0]  ch_b,
  input  logic [lcs3_pkg::CH_W-1:0]  ch_c,
  output lcs3_pkg::cell_rsp_t        rsp
);
  import lcs3_pkg::*;

  cell_issue_t        s1_r;
  logic [LEN_W-1:0]   plane_rd;
  logic [2*LEN_W-1:0] row_rd;
  logic [2*LEN_W-1:0] row_q;
  logic [2*LEN_W-1:0] row_wd;
  logic               pfwd_r;
  logic [LEN_W-1:0]   pfwd_d_r;
  logic               rfwd_r;
  logic [2*LEN_W-1:0] rfwd_d_r;
  logic [LEN_W-1:0]   d_r;
  logic [LEN_W-1:0]   z_r;
  logic [LEN_W-1:0]   x, y, z, d, m, v;
  logic               match;

  // plane memory holds the previous plane at (j,k) until overwritten
  lcs3_ram #(.WIDTH(LEN_W), .DEPTH(PLANE_DEPTH)) u_plane (
    .clk   (clk),
    .we    (s1_r.valid),
    .waddr (s1_r.paddr),
    .wdata (v),
    .raddr (issue.paddr),
    .rdata (plane_rd)
  );

  // row memory: {current plane row j-1, previous plane row j-1}
  lcs3_ram #(.WIDTH(2 * LEN_W), .DEPTH(MAX_LEN)) u_row (
    .clk   (clk),
    .we    (s1_r.valid),
    .waddr (s1_r.kaddr),
    .wdata (row_wd),
    .raddr (issue.kaddr),
    .rdata (row_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r   <= '0;
      pfwd_r <= 1'b0;
      rfwd_r <= 1'b0;
    end else begin
      s1_r   <= issue;
      // read and write of one entry in the same cycle: take the new data
      pfwd_r <= s1_r.valid && (s1_r.paddr == issue.paddr);
      rfwd_r <= s1_r.valid && (s1_r.kaddr == issue.kaddr);
    end
    pfwd_d_r <= v;
    rfwd_d_r <= row_wd;
    if (s1_r.valid) begin
      d_r <= row_q[LEN_W-1:0];
      z_r <= v;
    end
  end

  always_comb begin
    row_q = rfwd_r ? rfwd_d_r : row_rd;
    x     = s1_r.first_plane ? '0 : (pfwd_r ? pfwd_d_r : plane_rd);
    y     = s1_r.first_row ? '0 : row_q[2*LEN_W-1:LEN_W];
    z     = s1_r.first_col ? '0 : z_r;
    d     = (s1_r.first_plane || s1_r.first_row || s1_r.first_col) ? '0 : d_r;
    match = (ch_a == ch_b) && (ch_b == ch_c);
    m     = x;
    if (y > m) begin
      m = y;
    end
    if (z > m) begin
      m = z;
    end
    v      = match ? (d + LEN_W'(1)) : m;
    row_wd = {v, x};
  end

  assign rsp.valid = s1_r.valid && s1_r.last;
  assign rsp.score = v;

endmodule

>>> tb/tb_lcs_length_three_strings.sv
// testbench for the three-string lcs length engine: directed, full, backpressure, random
module tb_lcs_length_three_strings;
  import lcs3_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 20;
  localparam int RANDOM_ITEMS = 180;

  typedef struct packed {
    logic [LCS_W-1:0] lcs_len;
    logic             overflow;
  } lcs_result_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  logic [CMD_W-1:0] in_cmd    = CMD_APPEND_A;
  logic [CH_W-1:0]  in_ch     = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [LCS_W-1:0] out_lcs_len;
  logic             out_overflow;

  // shadow copy of the loaded strings
  logic [CH_W-1:0]  seq_a [MAX_LEN];
  logic [CH_W-1:0]  seq_b [MAX_LEN];
  logic [CH_W-1:0]  seq_c [MAX_LEN];
  int               len_a = 0;
  int               len_b = 0;
  int               len_c = 0;
  logic             dropped_char = 1'b0;
  logic [LCS_W-1:0] score [2][MAX_LEN+1][MAX_LEN+1];

  lcs_result_t      expected_results [$];
  int               error_count   = 0;
  int               items_sent    = 0;
  int               cycle_count   = 0;
  logic             no_idle       = 1'b0;
  logic             hold_req      = 1'b0;
  logic             hold_active   = 1'b0;

  lcs_length_three_strings dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_ch        (in_ch),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_lcs_len  (out_lcs_len),
    .out_overflow (out_overflow)
  );

  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  // three-way lcs over the shadow strings, two planes of the table
  function automatic logic [LCS_W-1:0] lcs_of_loaded();
    int               cur;
    int               prv;
    logic [LCS_W-1:0] best;
    for (int p = 0; p < 2; p++)
      for (int j = 0; j <= MAX_LEN; j++)
        for (int k = 0; k <= MAX_LEN; k++)
          score[p][j][k] = '0;
    for (int i = 1; i <= len_a; i++) begin
      cur = i % 2;
      prv = 1 - cur;
      for (int j = 1; j <= len_b; j++) begin
        for (int k = 1; k <= len_c; k++) begin
          if (seq_a[i-1] == seq_b[j-1] && seq_b[j-1] == seq_c[k-1]) begin
            score[cur][j][k] = score[prv][j-1][k-1] + 1'b1;
          end else begin
            best = score[prv][j][k];
            if (score[cur][j-1][k] > best) best = score[cur][j-1][k];
            if (score[cur][j][k-1] > best) best = score[cur][j][k-1];
            score[cur][j][k] = best;
          end
        end
      end
    end
    return score[len_a % 2][len_b][len_c];
  endfunction

  function automatic void predict_accept(cmd_t cmd, logic [CH_W-1:0] ch);
    lcs_result_t res;
    case (cmd)
      CMD_APPEND_A: begin
        if (len_a < MAX_LEN) begin
          seq_a[len_a] = ch;
          len_a++;
        end else dropped_char = 1'b1;
      end
      CMD_APPEND_B: begin
        if (len_b < MAX_LEN) begin
          seq_b[len_b] = ch;
          len_b++;
        end else dropped_char = 1'b1;
      end
      CMD_APPEND_C: begin
        if (len_c < MAX_LEN) begin
          seq_c[len_c] = ch;
          len_c++;
        end else dropped_char = 1'b1;
      end
      CMD_COMPUTE: begin
        res.lcs_len  = lcs_of_loaded();
        res.overflow = dropped_char;
        expected_results.push_back(res);
        len_a        = 0;
        len_b        = 0;
        len_c        = 0;
        dropped_char = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(string what);
    error_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  task automatic send_item(cmd_t cmd, logic [CH_W-1:0] ch);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_ch    <= ch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    predict_accept(cmd, ch);
  endtask

  // interleaved loads of three short strings, mostly over a narrow alphabet, then a compute
  task automatic send_random_set(int longest);
    int              remain [3];
    int              pick;
    int              span;
    logic [CH_W-1:0] base;
    for (int s = 0; s < 3; s++)
      remain[s] = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, longest);
    base = CH_W'($urandom);
    span = ($urandom_range(0, 6) == 0) ? 256 : $urandom_range(1, 4);
    while (remain[0] + remain[1] + remain[2] > 0) begin
      do pick = $urandom_range(0, 2); while (remain[pick] == 0);
      remain[pick]--;
      send_item(cmd_t'(pick), base + CH_W'($urandom_range(0, span - 1)));
    end
    send_item(CMD_COMPUTE, CH_W'($urandom));
  endtask

  task automatic test_directed_cases();
    // nothing loaded
    send_item(CMD_COMPUTE, 8'h00);
    // single characters at the bottom of the byte range
    send_item(CMD_APPEND_A, 8'h00);
    send_item(CMD_APPEND_B, 8'h00);
    send_item(CMD_APPEND_C, 8'h00);
    send_item(CMD_COMPUTE, 8'hFF);
    // top of the byte range, third string off by the low bit
    send_item(CMD_APPEND_A, 8'hFF);
    send_item(CMD_APPEND_B, 8'hFF);
    send_item(CMD_APPEND_C, 8'hFE);
    send_item(CMD_COMPUTE, 8'h5A);
    // string c left empty
    send_item(CMD_APPEND_A, 8'hAA);
    send_item(CMD_APPEND_B, 8'hAA);
    send_item(CMD_COMPUTE, 8'hA5);
    // interleaved loading, common subsequence is 05 07
    send_item(CMD_APPEND_C, 8'h05);
    send_item(CMD_APPEND_B, 8'h05);
    send_item(CMD_APPEND_A, 8'h05);
    send_item(CMD_APPEND_A, 8'h07);
    send_item(CMD_APPEND_C, 8'h07);
    send_item(CMD_APPEND_B, 8'h09);
    send_item(CMD_APPEND_B, 8'h07);
    send_item(CMD_COMPUTE, 8'h3C);
  endtask

  task automatic test_full_strings();
    logic [CH_W-1:0] pattern [MAX_LEN];
    int              extra;
    foreach (pattern[n]) pattern[n] = CH_W'($urandom);
    // identical full strings give the largest length; extras on b are dropped
    for (int n = 0; n < MAX_LEN; n++) begin
      send_item(CMD_APPEND_A, pattern[n]);
      send_item(CMD_APPEND_B, pattern[n]);
      send_item(CMD_APPEND_C, pattern[n]);
    end
    extra = $urandom_range(1, 3);
    repeat (extra) send_item(CMD_APPEND_B, CH_W'($urandom));
    send_item(CMD_COMPUTE, CH_W'($urandom));
  endtask

  task automatic test_output_backpressure();
    in_valid <= 1'b0;
    // let the long walk finish so the hold meets an idle block
    while (expected_results.size() != 0) @(posedge clk);
    hold_req = 1'b1;
    wait (hold_active);
    // back to back computes while the result side is blocked
    no_idle = 1'b1;
    repeat (4) send_random_set(2);
    no_idle = 1'b0;
  endtask

  task automatic test_random_sequences();
    int items_start;
    int r;
    items_start = items_sent;
    while (items_sent - items_start < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        repeat ($urandom_range(1, 4))
          send_item(cmd_t'($urandom_range(0, 3)), CH_W'($urandom));
      end else if (r < 13) begin
        send_random_set(16);
      end else begin
        send_random_set(5);
      end
      if ($urandom_range(0, 19) == 0) no_idle = !no_idle;
    end
    no_idle = 1'b0;
  endtask

  initial begin : receiver
    int gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_active = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req    = 1'b0;
        hold_active = 1'b0;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_result
    lcs_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: len %0d overflow %0b",
                                  out_lcs_len, out_overflow));
      end else begin
        want = expected_results.pop_front();
        if (out_lcs_len !== want.lcs_len)
          report_mismatch($sformatf("lcs_len %0d, expected %0d", out_lcs_len, want.lcs_len));
        if (out_overflow !== want.overflow)
          report_mismatch($sformatf("overflow %0b, expected %0b", out_overflow, want.overflow));
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : main_sequence
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_full_strings();
    test_output_backpressure();
    test_random_sequences();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/lcs3_pkg.sv
sv/lcs3_ram.sv
sv/lcs3_ctrl.sv
sv/lcs3_cell.sv
sv/lcs_length_three_strings.sv
tb/tb_lcs_length_three_strings.sv
